### sv/tbv_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbv_pkg
// Types and constants shared by the tour builder visited-set unit.
// ---------------------------------------------------------------------------
package tbv_pkg;

	localparam int MAX_CITIES_DEF = 64;
	localparam int CITY_CAP       = 64;
	localparam int CITY_W         = 6;
	localparam int CNT_W          = 7;
	localparam int IN_DATA_W      = 8;
	localparam int OUT_DATA_W     = 24;

	typedef enum logic [1:0] {
		MODE_INIT = 2'd0,
		MODE_PUSH = 2'd1,
		MODE_POP  = 2'd2,
		MODE_LIST = 2'd3
	} mode_t;

	typedef enum logic [2:0] {
		ST_SWEEP,
		ST_IDLE,
		ST_EXEC,
		ST_INIT_RESP,
		ST_LIST_RD,
		ST_LIST_CHK,
		ST_LIST_END
	} state_t;

	typedef struct packed {
		logic              last;
		logic              listed_valid;
		logic [CITY_W-1:0] listed_city;
		logic              finished;
		logic [CNT_W-1:0]  current_city;
		logic [CNT_W-1:0]  tour_length;
		logic              accepted;
	} result_t;

endpackage

### sv/tbv_ram.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbv_ram
// Simple dual-port synchronous RAM, one write and one registered read port.
// ---------------------------------------------------------------------------
module tbv_ram #(
	parameter int DEPTH = 64,
	parameter int WIDTH = 1,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

### sv/tbv_out_stage.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tbv_out_stage
// Output register of the result stream; loads when empty or being drained.
// ---------------------------------------------------------------------------
module tbv_out_stage
	import tbv_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  load,
	input  result_t               res,
	output logic                  free,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// accepted, tour_length[6:0], current_city[6:0], finished, listed_city[5:0], pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// listed_valid
	output logic                  m_axis_tuser,
	output logic                  m_axis_tlast
);

	logic    valid_q;
	result_t res_q;

	assign free = !valid_q || m_axis_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (free) begin
			valid_q <= load;
		end
	end

	always_ff @(posedge clk) begin
		if (free && load) begin
			res_q <= res;
		end
	end

	assign m_axis_tvalid = valid_q;
	assign m_axis_tdata  = {2'b00, res_q.listed_city, res_q.finished, res_q.current_city,
		res_q.tour_length, res_q.accepted};
	assign m_axis_tuser  = res_q.listed_valid;
	assign m_axis_tlast  = res_q.last;

endmodule

### sv/tour_builder_visited_set_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tour_builder_visited_set_unit
// Partial tour builder: free-city bitmap and tour stack in RAM, step FSM.
// ---------------------------------------------------------------------------
// channel   direction  fields
// s_axis    in         tdata: mode[1:0], city[7:2]
// m_axis    out        tdata: see port; tuser: listed_valid; tlast: last
// cfg       in         data: city_count[6:0]
//
// Push and pop: RAM read, then modify/write and result. Init: a sweep
// writes one bitmap entry per cycle, then the result. List: each city
// below city_count is read through the single bitmap read port and checked.
// After reset a clearing pass over all NCITY entries marks all cities free;
// no request is taken meanwhile. A stalled result register holds the FSM.
// ---------------------------------------------------------------------------
module tour_builder_visited_set_unit
	import tbv_pkg::*;
#(
	parameter int MAX_CITIES = MAX_CITIES_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  s_axis_tvalid,
	output logic                  s_axis_tready,
	// mode[1:0], city[7:2]
	input  logic [IN_DATA_W-1:0]  s_axis_tdata,
	output logic                  m_axis_tvalid,
	input  logic                  m_axis_tready,
	// accepted, tour_length[6:0], current_city[6:0], finished, listed_city[5:0], pad
	output logic [OUT_DATA_W-1:0] m_axis_tdata,
	// listed_valid
	output logic                  m_axis_tuser,
	output logic                  m_axis_tlast,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CNT_W-1:0]      cfg_data
);

	localparam int NCITY = (MAX_CITIES < CITY_CAP) ? MAX_CITIES : CITY_CAP;
	localparam int AW    = $clog2(NCITY);
	localparam int IW    = $clog2(NCITY + 1);
	localparam logic [IW-1:0]    IDX_ONE  = IW'(1);
	localparam logic [IW-1:0]    IDX_END  = IW'(NCITY - 1);
	localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(NCITY);

	state_t            state_q, state_d;
	mode_t             mode_q, mode_d;
	logic [CITY_W-1:0] city_q, city_d;
	logic [CNT_W-1:0]  count_q, count_d;
	logic [CITY_W-1:0] top_q, top_d;
	logic [IW-1:0]     idx_q, idx_d;
	logic [CNT_W-1:0]  lim_q, lim_d;
	logic              resp_q, resp_d;
	logic              pend_q, pend_d;
	logic [CITY_W-1:0] pend_city_q, pend_city_d;
	logic [CNT_W-1:0]  city_count_q;

	logic [CNT_W-1:0]  n_eff;
	mode_t             in_mode;
	logic [CITY_W-1:0] in_city;
	logic              in_acc;

	logic              fm_we, fm_wdata, fm_re, fm_rdata;
	logic [AW-1:0]     fm_waddr, fm_raddr;
	logic              st_we, st_re;
	logic [AW-1:0]     st_waddr, st_raddr;
	logic [CITY_W-1:0] st_wdata, st_rdata;

	logic              out_load, out_free;
	result_t           out_res;

	logic              push_ok;
	logic [CNT_W-1:0]  cnt_m2;

	assign in_mode = mode_t'(s_axis_tdata[1:0]);
	assign in_city = s_axis_tdata[7:2];
	assign in_acc  = s_axis_tvalid && s_axis_tready;
	assign s_axis_tready = (state_q == ST_IDLE);
	assign cfg_ready = 1'b1;
	assign cnt_m2 = count_q - CNT_W'(2);

	always_comb begin
		if (city_count_q == '0) begin
			n_eff = CNT_W'(1);
		end else if (city_count_q > CNT_MAX) begin
			n_eff = CNT_MAX;
		end else begin
			n_eff = city_count_q;
		end
	end

	assign push_ok = ({1'b0, city_q} < n_eff) && fm_rdata && (count_q < CNT_MAX);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			city_count_q <= CNT_W'(CITY_CAP);
		end else if (cfg_valid && cfg_ready) begin
			city_count_q <= cfg_data;
		end
	end

	always_comb begin
		state_d     = state_q;
		mode_d      = mode_q;
		city_d      = city_q;
		count_d     = count_q;
		top_d       = top_q;
		idx_d       = idx_q;
		lim_d       = lim_q;
		resp_d      = resp_q;
		pend_d      = pend_q;
		pend_city_d = pend_city_q;
		fm_we       = 1'b0;
		fm_waddr    = idx_q[AW-1:0];
		fm_wdata    = 1'b0;
		fm_re       = 1'b0;
		fm_raddr    = in_city[AW-1:0];
		st_we       = 1'b0;
		st_waddr    = count_q[AW-1:0];
		st_wdata    = city_q;
		st_re       = 1'b0;
		st_raddr    = cnt_m2[AW-1:0];
		out_load    = 1'b0;

		out_res.accepted     = 1'b0;
		out_res.tour_length  = count_q;
		out_res.current_city = (count_q == '0) ? n_eff : {1'b0, top_q};
		out_res.finished     = (count_q == n_eff);
		out_res.listed_city  = '0;
		out_res.listed_valid = 1'b0;
		out_res.last         = 1'b1;

		unique case (state_q)
			ST_SWEEP: begin
				fm_we    = 1'b1;
				fm_wdata = (32'(idx_q) < 32'(lim_q));
				idx_d    = idx_q + IDX_ONE;
				if (idx_q == IDX_END) begin
					state_d = resp_q ? ST_INIT_RESP : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_acc) begin
					mode_d = in_mode;
					city_d = in_city;
					unique case (in_mode)
						MODE_INIT: begin
							count_d = '0;
							idx_d   = '0;
							lim_d   = n_eff;
							resp_d  = 1'b1;
							state_d = ST_SWEEP;
						end
						MODE_PUSH: begin
							fm_re   = 1'b1;
							state_d = ST_EXEC;
						end
						MODE_POP: begin
							st_re   = 1'b1;
							state_d = ST_EXEC;
						end
						MODE_LIST: begin
							idx_d   = '0;
							pend_d  = 1'b0;
							state_d = ST_LIST_RD;
						end
						default: ;
					endcase
				end
			end
			ST_EXEC: begin
				if (mode_q == MODE_PUSH) begin
					out_res.accepted = push_ok;
					if (push_ok) begin
						count_d = count_q + CNT_W'(1);
						top_d   = city_q;
					end
				end else begin
					out_res.accepted = (count_q != '0);
					if (count_q != '0) begin
						count_d = count_q - CNT_W'(1);
						top_d   = st_rdata;
					end
				end
				out_res.tour_length  = count_d;
				out_res.current_city = (count_d == '0) ? n_eff : {1'b0, top_d};
				out_res.finished     = (count_d == n_eff);
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
					if (mode_q == MODE_PUSH) begin
						fm_we    = push_ok;
						fm_waddr = city_q[AW-1:0];
						fm_wdata = 1'b0;
						st_we    = push_ok;
					end else begin
						fm_we    = (count_q != '0);
						fm_waddr = top_q[AW-1:0];
						fm_wdata = 1'b1;
					end
				end else begin
					count_d = count_q;
					top_d   = top_q;
				end
			end
			ST_INIT_RESP: begin
				out_res.accepted = 1'b1;
				if (out_free) begin
					out_load = 1'b1;
					resp_d   = 1'b0;
					state_d  = ST_IDLE;
				end
			end
			ST_LIST_RD: begin
				fm_re    = 1'b1;
				fm_raddr = idx_q[AW-1:0];
				state_d  = ST_LIST_CHK;
			end
			ST_LIST_CHK: begin
				out_res.listed_city  = pend_city_q;
				out_res.listed_valid = 1'b1;
				out_res.last         = 1'b0;
				if (!(fm_rdata && pend_q) || out_free) begin
					out_load = fm_rdata && pend_q;
					if (fm_rdata) begin
						pend_d      = 1'b1;
						pend_city_d = CITY_W'(idx_q);
					end
					idx_d   = idx_q + IDX_ONE;
					state_d = (32'(idx_q) + 1 == 32'(n_eff)) ? ST_LIST_END : ST_LIST_RD;
				end
			end
			ST_LIST_END: begin
				out_res.listed_city  = pend_q ? pend_city_q : '0;
				out_res.listed_valid = pend_q;
				if (out_free) begin
					out_load = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_SWEEP;
			mode_q  <= MODE_INIT;
			count_q <= '0;
			idx_q   <= '0;
			lim_q   <= CNT_MAX;
			resp_q  <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			mode_q  <= mode_d;
			count_q <= count_d;
			idx_q   <= idx_d;
			lim_q   <= lim_d;
			resp_q  <= resp_d;
			pend_q  <= pend_d;
		end
	end

	always_ff @(posedge clk) begin
		city_q      <= city_d;
		top_q       <= top_d;
		pend_city_q <= pend_city_d;
	end

	tbv_ram #(
		.DEPTH (NCITY),
		.WIDTH (1)
	) u_free_map (
		.clk   (clk),
		.we    (fm_we),
		.waddr (fm_waddr),
		.wdata (fm_wdata),
		.re    (fm_re),
		.raddr (fm_raddr),
		.rdata (fm_rdata)
	);

	tbv_ram #(
		.DEPTH (NCITY),
		.WIDTH (CITY_W)
	) u_tour_stack (
		.clk   (clk),
		.we    (st_we),
		.waddr (st_waddr),
		.wdata (st_wdata),
		.re    (st_re),
		.raddr (st_raddr),
		.rdata (st_rdata)
	);

	tbv_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.load          (out_load),
		.res           (out_res),
		.free          (out_free),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_MAX)
		else $error("tour stack depth beyond city capacity");

	a_push_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && mode_q == MODE_PUSH && out_free && push_ok)
		|=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted push did not grow the tour");

	a_pop_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EXEC && mode_q == MODE_POP && count_q == '0) |=> count_q == '0)
		else $error("pop on empty tour changed depth");

endmodule
